// File: hdl/assert_macros.svh
// assertion helpers used by the checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, off while reset is low
`define MLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form: whenever ante holds, cons must hold in the same cycle
`define MLR_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MLR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: hdl/mlr_pkg.sv
`default_nettype none

package mlr_pkg;

  localparam int unsigned CoordBits   = 12;
  localparam int unsigned PosBits     = CoordBits + 1;
  localparam int unsigned DecBits     = CoordBits + 3;
  localparam int unsigned InDataBits  = 4 * CoordBits;
  localparam int unsigned OutDataBits = 2 * CoordBits;

  // output queue sizing, depth must stay a power of two
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrBits = $clog2(FifoDepth);
  localparam int unsigned FifoCntBits = FifoPtrBits + 1;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef struct packed {
    logic                        last;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } pixel_t;

  // push_b is only ever set together with push_a
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

`default_nettype wire

// File: hdl/mlr_out_fifo.sv
`default_nettype none

module mlr_out_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mlr_pkg::push_t  push_i,
  input  wire mlr_pkg::pixel_t data_a_i,
  input  wire mlr_pkg::pixel_t data_b_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output mlr_pkg::pixel_t      data_o
);

  mlr_pkg::pixel_t mem_q [mlr_pkg::FifoDepth];

  logic [mlr_pkg::FifoPtrBits-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_b;
  logic [mlr_pkg::FifoPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [mlr_pkg::FifoCntBits-1:0] count_q, count_d, n_push;
  logic                            pop;

  assign wr_ptr_b = wr_ptr_q + mlr_pkg::FifoPtrBits'(1);
  assign n_push   = mlr_pkg::FifoCntBits'(push_i.push_a) + mlr_pkg::FifoCntBits'(push_i.push_b);
  assign valid_o  = (count_q != '0);
  assign pop      = valid_o && ready_i;
  assign room_o   = (count_q <= mlr_pkg::FifoCntBits'(mlr_pkg::FifoDepth - 2));
  assign data_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + n_push[mlr_pkg::FifoPtrBits-1:0];
  assign rd_ptr_d = rd_ptr_q + mlr_pkg::FifoPtrBits'(pop);
  assign count_d  = count_q + n_push - mlr_pkg::FifoCntBits'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wr_ptr_b] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/midpoint_line_rasterizer.sv
// flow: an item is registered on acceptance, then processed into the output queue
// once the queue has room for both pixels of a load; pixels leave from the queue
// throughput: one step item per cycle while the output queue has room; a load item
// pushes two pixels through the single output port, so back-to-back loads fill the queue and stall the input
// reset: rst_ni clears line state, input register and output queue (no pixels pending)
`default_nettype none

module midpoint_line_rasterizer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // slave side: one item per handshake
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: start_x [11:0], start_y [23:12], end_x [35:24], end_y [47:36]
  input  wire logic [mlr_pkg::InDataBits-1:0]  s_axis_tdata_i,
  // tuser: action [0]
  input  wire logic                            s_axis_tuser_i,
  // master side: one pixel per handshake
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: pixel_x [11:0], pixel_y [23:12]
  output logic [mlr_pkg::OutDataBits-1:0]      m_axis_tdata_o,
  // tlast: last pixel of the line
  output logic                                 m_axis_tlast_o
);

  localparam int unsigned CB = mlr_pkg::CoordBits;
  localparam int unsigned PB = mlr_pkg::PosBits;
  localparam int unsigned DB = mlr_pkg::DecBits;

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic                  in_valid_q;
  mlr_pkg::action_e      act_q;
  logic signed [CB-1:0]  sx_q, sy_q, ex_q, ey_q;
  logic                  room;
  logic                  process;
  logic                  in_acc;

  // an item is worked off once the queue can take both pixels of a load
  assign process         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || process;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= mlr_pkg::action_e'(s_axis_tuser_i);
      sx_q  <= s_axis_tdata_i[CB-1:0];
      sy_q  <= s_axis_tdata_i[2*CB-1:CB];
      ex_q  <= s_axis_tdata_i[3*CB-1:2*CB];
      ey_q  <= s_axis_tdata_i[4*CB-1:3*CB];
    end
  end

  // ---------------------------------------------------------------------------
  // line state, kept in first-octant (folded) coordinates
  // ---------------------------------------------------------------------------
  logic                 active_q, active_d;
  logic                 swap_q, swap_d;
  logic                 neg_x_q, neg_x_d;
  logic                 neg_y_q, neg_y_d;
  logic signed [PB-1:0] maj_pos_q, maj_pos_d;
  logic signed [PB-1:0] min_pos_q, min_pos_d;
  logic signed [PB-1:0] maj_end_q, maj_end_d;
  logic signed [PB-1:0] min_dlt_q, min_dlt_d;
  logic signed [PB-1:0] nmaj_dlt_q, nmaj_dlt_d;
  logic signed [DB-1:0] dec_q, dec_d;

  // ---------------------------------------------------------------------------
  // load: fold the endpoints into the first octant
  // ---------------------------------------------------------------------------
  logic signed [PB-1:0] sx_w, sy_w, ex_w, ey_w;
  logic signed [PB-1:0] dx, dy, adx, ady;
  logic                 l_swap, l_neg_x, l_neg_y;
  logic signed [PB-1:0] fx1, fy1, fx2, fy2;
  logic signed [PB-1:0] l_maj_pos, l_min_pos, l_maj_end, l_min_end;
  logic signed [PB-1:0] l_min_dlt, l_nmaj_dlt;
  logic signed [DB-1:0] l_twice, l_dec;
  logic                 l_single;

  assign sx_w = PB'(sx_q);
  assign sy_w = PB'(sy_q);
  assign ex_w = PB'(ex_q);
  assign ey_w = PB'(ey_q);

  assign dx  = ex_w - sx_w;
  assign dy  = ey_w - sy_w;
  assign adx = dx[PB-1] ? -dx : dx;
  assign ady = dy[PB-1] ? -dy : dy;

  // steep lines swap axes so x stays the major axis
  assign l_swap  = adx < ady;
  assign l_neg_x = ex_w < sx_w;
  assign l_neg_y = ey_w < sy_w;

  assign fx1 = l_neg_x ? -sx_w : sx_w;
  assign fx2 = l_neg_x ? -ex_w : ex_w;
  assign fy1 = l_neg_y ? -sy_w : sy_w;
  assign fy2 = l_neg_y ? -ey_w : ey_w;

  assign l_maj_pos = l_swap ? fy1 : fx1;
  assign l_min_pos = l_swap ? fx1 : fy1;
  assign l_maj_end = l_swap ? fy2 : fx2;
  assign l_min_end = l_swap ? fx2 : fy2;

  // folding leaves the minor extent non-negative; the major extent is kept negated
  assign l_min_dlt  = l_min_end - l_min_pos;
  assign l_nmaj_dlt = l_maj_pos - l_maj_end;

  // (2*minor - major) / 2, rounded toward zero: bias negatives up by one
  assign l_twice = (DB'(l_min_dlt) <<< 1) + DB'(l_nmaj_dlt);
  assign l_dec   = (l_twice + $signed(DB'(l_twice[DB-1]))) >>> 1;

  assign l_single = !(l_maj_pos < l_maj_end);

  // ---------------------------------------------------------------------------
  // step: one midpoint iteration
  // ---------------------------------------------------------------------------
  logic                 s_diag;
  logic signed [PB-1:0] s_maj_pos, s_min_pos;
  logic signed [DB-1:0] s_dec;
  logic                 s_done;
  logic signed [PB-1:0] ux, uy;

  // a positive decision also steps the minor axis
  assign s_diag    = dec_q > DB'(0);
  assign s_maj_pos = maj_pos_q + PB'(1);
  assign s_min_pos = s_diag ? min_pos_q + PB'(1) : min_pos_q;
  assign s_dec     = dec_q + DB'(min_dlt_q) + (s_diag ? DB'(nmaj_dlt_q) : DB'(0));
  assign s_done    = !(s_maj_pos < maj_end_q);

  // unfold back to screen space
  always_comb begin
    ux = swap_q ? s_min_pos : s_maj_pos;
    uy = swap_q ? s_maj_pos : s_min_pos;
    if (neg_x_q) begin
      ux = -ux;
    end
    if (neg_y_q) begin
      uy = -uy;
    end
  end

  // ---------------------------------------------------------------------------
  // next state and pixel pushes
  // ---------------------------------------------------------------------------
  mlr_pkg::push_t  push;
  mlr_pkg::pixel_t pix_a, pix_b;

  always_comb begin
    active_d   = active_q;
    swap_d     = swap_q;
    neg_x_d    = neg_x_q;
    neg_y_d    = neg_y_q;
    maj_pos_d  = maj_pos_q;
    min_pos_d  = min_pos_q;
    maj_end_d  = maj_end_q;
    min_dlt_d  = min_dlt_q;
    nmaj_dlt_d = nmaj_dlt_q;
    dec_d      = dec_q;
    push       = '0;

    // start pixel then end pixel for a load, the stepped pixel otherwise
    pix_a.x    = (act_q == mlr_pkg::ACT_LOAD) ? sx_q : ux[CB-1:0];
    pix_a.y    = (act_q == mlr_pkg::ACT_LOAD) ? sy_q : uy[CB-1:0];
    pix_a.last = (act_q == mlr_pkg::ACT_LOAD) ? 1'b0 : s_done;
    pix_b.x    = ex_q;
    pix_b.y    = ey_q;
    pix_b.last = l_single;

    if (process) begin
      case (act_q)
        mlr_pkg::ACT_LOAD: begin
          active_d    = !l_single;
          swap_d      = l_swap;
          neg_x_d     = l_neg_x;
          neg_y_d     = l_neg_y;
          maj_pos_d   = l_maj_pos;
          min_pos_d   = l_min_pos;
          maj_end_d   = l_maj_end;
          min_dlt_d   = l_min_dlt;
          nmaj_dlt_d  = l_nmaj_dlt;
          dec_d       = l_dec;
          push.push_a = 1'b1;
          push.push_b = 1'b1;
        end
        mlr_pkg::ACT_STEP: begin
          // a step with no line in flight is dropped
          if (active_q) begin
            active_d    = !s_done;
            maj_pos_d   = s_maj_pos;
            min_pos_d   = s_min_pos;
            dec_d       = s_dec;
            push.push_a = 1'b1;
          end
        end
        default: begin
          push = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      swap_q     <= 1'b0;
      neg_x_q    <= 1'b0;
      neg_y_q    <= 1'b0;
      maj_pos_q  <= '0;
      min_pos_q  <= '0;
      maj_end_q  <= '0;
      min_dlt_q  <= '0;
      nmaj_dlt_q <= '0;
      dec_q      <= '0;
    end else begin
      active_q   <= active_d;
      swap_q     <= swap_d;
      neg_x_q    <= neg_x_d;
      neg_y_q    <= neg_y_d;
      maj_pos_q  <= maj_pos_d;
      min_pos_q  <= min_pos_d;
      maj_end_q  <= maj_end_d;
      min_dlt_q  <= min_dlt_d;
      nmaj_dlt_q <= nmaj_dlt_d;
      dec_q      <= dec_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output queue, decouples the two-pixel load burst from the master side
  // ---------------------------------------------------------------------------
  mlr_pkg::pixel_t out_pix;

  mlr_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_a_i (pix_a),
    .data_b_i (pix_b),
    .room_o   (room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .data_o   (out_pix)
  );

  assign m_axis_tdata_o = {out_pix.y, out_pix.x};
  assign m_axis_tlast_o = out_pix.last;

endmodule

`default_nettype wire

// File: hdl/mlr_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mlr_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [mlr_pkg::OutDataBits-1:0] m_axis_tdata_o,
  input wire logic                            m_axis_tlast_o
);

  logic                          out_acc;
  logic                          out_stall;
  logic                          last_acc;
  logic [mlr_pkg::OutDataBits:0] out_word;

  assign out_acc   = m_axis_tvalid_o && m_axis_tready_i;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign last_acc  = out_acc && m_axis_tlast_o;
  assign out_word  = {m_axis_tlast_o, m_axis_tdata_o};

  // a stalled pixel stays offered
  `MLR_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o, "output valid dropped while stalled")

  // a stalled pixel keeps its value
  `MLR_ASSERT(a_out_stable, out_stall |=> $stable(out_word), "output pixel changed while stalled")

  // back pressure on the input only comes from pixels waiting at the output
  `MLR_ASSERT_IMPL(a_stall_cause, !s_axis_tready_o, m_axis_tvalid_o, "input stalled, no pixel pending")

  // the pixel after a line end is a start pixel, never another line end
  `MLR_ASSERT_IMPL(a_no_double_last, $past(last_acc) && out_acc, !m_axis_tlast_o, "two line ends in a row")

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);

`default_nettype wire
